>>> rtl/fjfm_pkg.sv
// ----------------------------------------------------------------------------
// fjfm_pkg
// Shared types and constants of the feeder jam and fire mode controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fjfm_pkg;

    localparam int unsigned SlotW   = 20;
    localparam int unsigned CfgW    = 20;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned PosW    = 32;
    localparam int unsigned CntW    = 16;
    localparam int unsigned DivCntW = 5;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_STATIC = 2'd1,
        MODE_FIRE   = 2'd2,
        MODE_BACK   = 2'd3
    } mode_t;

    typedef enum logic [CfgIdxW-1:0] {
        REG_SLOT_COUNTS = 3'd0,
        REG_FWD_TORQUE  = 3'd1,
        REG_REV_TORQUE  = 3'd2,
        REG_FWD_TICKS   = 3'd3,
        REG_REV_TICKS   = 3'd4,
        REG_DONE_WINDOW = 3'd5,
        REG_FIRE_SPEED  = 3'd6,
        REG_HEAT_RES    = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_FIRE,
        S_CHECK,
        S_DONE
    } ctl_state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic div_step;
        logic fire_load;
        logic check;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic next_fire;
        logic next_back;
        logic out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/fjfm_ctrl.sv
// ----------------------------------------------------------------------------
// fjfm_ctrl
// Sequencer: capture, evaluate, remainder iterations, back-off check, output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fjfm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire fjfm_pkg::dp_stat_t stat,
    output fjfm_pkg::dp_cmd_t      cmd
);
    import fjfm_pkg::*;

    ctl_state_t           state_reg, state_next;
    logic [DivCntW-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cnt_next = '0;
                priority if (stat.next_fire)
                    state_next = S_DIV;
                else if (stat.next_back)
                    state_next = S_CHECK;
                else
                    state_next = S_DONE;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + DivCntW'(1);
                if (cnt_reg == '1)
                    state_next = S_FIRE;
            end
            S_FIRE:  state_next = S_DONE;
            S_CHECK: state_next = S_DONE;
            S_DONE:
            begin
                if (!stat.out_busy)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_EVAL:  cmd.eval      = 1'b1;
            S_DIV:   cmd.div_step  = 1'b1;
            S_FIRE:  cmd.fire_load = 1'b1;
            S_CHECK: cmd.check     = 1'b1;
            S_DONE:  cmd.out_load  = !stat.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/fjfm_dp.sv
// ----------------------------------------------------------------------------
// fjfm_dp
// Datapath: config registers, stall counters, mode state, remainder unit,
// back-off check and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fjfm_dp #(
    parameter int unsigned STALL_SPEED = 50
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire fjfm_pkg::dp_cmd_t             cmd,
    output fjfm_pkg::dp_stat_t                 stat,
    input  wire logic                          cfg_valid,
    input  wire logic [fjfm_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [fjfm_pkg::CfgW-1:0]     cfg_data,
    input  wire logic signed [15:0]            motor_speed,
    input  wire logic signed [31:0]            motor_position,
    input  wire logic signed [15:0]            drive_current,
    input  wire logic [15:0]                   barrel_heat,
    input  wire logic [15:0]                   barrel_heat_limit,
    input  wire logic                          stop_request,
    input  wire logic                          fire_request,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         feeder_mode,
    output logic signed [31:0]                 position_target,
    output logic signed [15:0]                 speed_target,
    output logic                               forward_jam,
    output logic                               reverse_jam,
    output logic                               heat_lockout
);
    import fjfm_pkg::*;

    // configuration
    logic [SlotW-1:0]  slot_reg;
    logic [14:0]       ftl_reg, rtl_reg;
    logic [15:0]       fjt_reg, rjt_reg;
    logic [19:0]       win_reg;
    logic [15:0]       fspd_reg;
    logic [9:0]        hres_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= 20'd36864;
            ftl_reg  <= 15'd5000;
            rtl_reg  <= 15'd5000;
            fjt_reg  <= 16'd100;
            rjt_reg  <= 16'd100;
            win_reg  <= 20'd1000;
            fspd_reg <= 16'd3000;
            hres_reg <= 10'd30;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_SLOT_COUNTS: slot_reg <= cfg_data;
                REG_FWD_TORQUE:  ftl_reg  <= cfg_data[14:0];
                REG_REV_TORQUE:  rtl_reg  <= cfg_data[14:0];
                REG_FWD_TICKS:   fjt_reg  <= cfg_data[15:0];
                REG_REV_TICKS:   rjt_reg  <= cfg_data[15:0];
                REG_DONE_WINDOW: win_reg  <= cfg_data;
                REG_FIRE_SPEED:  fspd_reg <= cfg_data[15:0];
                REG_HEAT_RES:    hres_reg <= cfg_data[9:0];
                default:         slot_reg <= slot_reg;
            endcase
        end
    end

    // captured item
    logic signed [15:0] spd_reg, drv_reg;
    logic signed [31:0] pos_reg;
    logic [15:0]        heat_reg, lim_reg;
    logic               stop_reg, fire_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            spd_reg  <= motor_speed;
            pos_reg  <= motor_position;
            drv_reg  <= drive_current;
            heat_reg <= barrel_heat;
            lim_reg  <= barrel_heat_limit;
            stop_reg <= stop_request;
            fire_reg <= fire_request;
        end
    end

    // state
    mode_t              mode_reg, mode_next;
    logic [PosW-1:0]    target_reg, target_next;
    logic [15:0]        speed_reg, speed_next;
    logic               pend_reg, pend_next;
    logic               fin_reg, fin_next;
    logic [CntW-1:0]    fcnt_reg, fcnt_next;
    logic [CntW-1:0]    rcnt_reg, rcnt_next;
    logic               fjam_reg, fjam_next;
    logic               rjam_reg, rjam_next;
    logic               lock_reg, lock_next;

    // remainder unit
    logic [PosW-1:0]    dvd_reg, dvd_next;
    logic [SlotW-1:0]   rem_reg, rem_next;
    logic [SlotW:0]     rem_sh;
    logic [SlotW:0]     rem_sub;

    // evaluation terms
    logic signed [16:0] margin;
    logic               lockout;
    logic               stalled, fup, rup;
    logic [CntW-1:0]    fc1, rc1;
    logic               fjam, rjam;
    mode_t              m0, m1;
    logic               p1, f1;
    logic [PosW-1:0]    abs_pos;
    logic signed [32:0] err;
    logic [32:0]        abs_err;

    assign margin  = $signed({1'b0, lim_reg}) - $signed({1'b0, heat_reg});
    assign lockout = margin[16] || (margin[15:0] < {6'd0, hres_reg});
    assign stalled = (spd_reg <= $signed(16'(STALL_SPEED)))
                  && (spd_reg >= -$signed(16'(STALL_SPEED)));
    assign fup = stalled && ($signed({drv_reg[15], drv_reg}) > $signed({2'b00, ftl_reg}));
    assign rup = stalled && ($signed({drv_reg[15], drv_reg}) < -$signed({2'b00, rtl_reg}));
    assign fc1 = fup ? ((fcnt_reg == '1) ? fcnt_reg : fcnt_reg + CntW'(1))
                     : ((fcnt_reg == '0) ? fcnt_reg : fcnt_reg - CntW'(1));
    assign rc1 = rup ? ((rcnt_reg == '1) ? rcnt_reg : rcnt_reg + CntW'(1))
                     : ((rcnt_reg == '0) ? rcnt_reg : rcnt_reg - CntW'(1));
    assign fjam = fc1 > fjt_reg;
    assign rjam = rc1 > rjt_reg;
    assign m0   = lockout ? MODE_STATIC : mode_reg;
    assign abs_pos = pos_reg[31] ? PosW'(-pos_reg) : PosW'(pos_reg);

    assign rem_sh  = {rem_reg, dvd_reg[PosW-1]};
    assign rem_sub = rem_sh - {1'b0, slot_reg};

    assign err     = $signed({pos_reg[31], pos_reg}) - $signed({target_reg[31], target_reg});
    assign abs_err = err[32] ? 33'(-err) : 33'(err);

    always_comb
    begin
        unique case (m0)
            MODE_IDLE:
            begin
                m1 = stop_reg ? MODE_IDLE : MODE_STATIC;
                p1 = pend_reg;
                f1 = fin_reg;
            end
            MODE_STATIC, MODE_FIRE:
            begin
                priority if (stop_reg)
                begin
                    m1 = MODE_IDLE;
                    p1 = pend_reg;
                    f1 = fin_reg;
                end
                else if (fjam)
                begin
                    m1 = MODE_BACK;
                    p1 = 1'b1;
                    f1 = 1'b0;
                end
                else
                begin
                    m1 = (fire_reg && !lockout) ? MODE_FIRE : MODE_STATIC;
                    p1 = pend_reg;
                    f1 = fin_reg;
                end
            end
            MODE_BACK:
            begin
                p1 = pend_reg;
                priority if (stop_reg)
                begin
                    m1 = MODE_IDLE;
                    f1 = fin_reg;
                end
                else if (!fin_reg && !rjam)
                begin
                    m1 = MODE_BACK;
                    f1 = fin_reg;
                end
                else
                begin
                    m1 = MODE_STATIC;
                    f1 = 1'b1;
                end
            end
            default:
            begin
                m1 = MODE_IDLE;
                p1 = pend_reg;
                f1 = fin_reg;
            end
        endcase
    end

    assign stat.next_fire = (m1 == MODE_FIRE);
    assign stat.next_back = (m1 == MODE_BACK);

    always_comb
    begin
        mode_next   = mode_reg;
        target_next = target_reg;
        speed_next  = speed_reg;
        pend_next   = pend_reg;
        fin_next    = fin_reg;
        fcnt_next   = fcnt_reg;
        rcnt_next   = rcnt_reg;
        fjam_next   = fjam_reg;
        rjam_next   = rjam_reg;
        lock_next   = lock_reg;
        dvd_next    = dvd_reg;
        rem_next    = rem_reg;
        priority if (cmd.eval)
        begin
            mode_next = m1;
            fjam_next = fjam;
            rjam_next = rjam;
            lock_next = lockout;
            pend_next = p1;
            fin_next  = f1;
            fcnt_next = fc1;
            rcnt_next = rc1;
            if ((m0 == MODE_BACK) && !stop_reg && !(!fin_reg && !rjam))
            begin
                fcnt_next = '0;
                rcnt_next = '0;
            end
            dvd_next = abs_pos;
            rem_next = '0;
            unique case (m1)
                MODE_IDLE:
                begin
                    speed_next  = '0;
                    target_next = pos_reg;
                    pend_next   = 1'b0;
                    fin_next    = 1'b1;
                end
                MODE_STATIC:
                begin
                    speed_next = '0;
                    fcnt_next  = '0;
                    rcnt_next  = '0;
                end
                MODE_FIRE:
                    speed_next = fspd_reg;
                MODE_BACK:
                begin
                    if (p1)
                        target_next = target_reg - PosW'(slot_reg);
                    pend_next = 1'b0;
                end
                default: speed_next = speed_reg;
            endcase
        end
        else if (cmd.div_step)
        begin
            dvd_next = {dvd_reg[PosW-2:0], 1'b0};
            rem_next = rem_sub[SlotW] ? rem_sh[SlotW-1:0] : rem_sub[SlotW-1:0];
        end
        else if (cmd.fire_load)
        begin
            // rem takes the sign of the position
            if (slot_reg == '0)
                target_next = pos_reg;
            else if (pos_reg[31])
                target_next = pos_reg + PosW'(slot_reg) + PosW'(rem_reg);
            else
                target_next = pos_reg + PosW'(slot_reg) - PosW'(rem_reg);
        end
        else if (cmd.check)
        begin
            if (abs_err < {13'd0, win_reg})
            begin
                fin_next  = 1'b1;
                fcnt_next = '0;
                rcnt_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            target_reg <= '0;
            speed_reg  <= '0;
            pend_reg   <= 1'b0;
            fin_reg    <= 1'b1;
            fcnt_reg   <= '0;
            rcnt_reg   <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            target_reg <= target_next;
            speed_reg  <= speed_next;
            pend_reg   <= pend_next;
            fin_reg    <= fin_next;
            fcnt_reg   <= fcnt_next;
            rcnt_reg   <= rcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fjam_reg <= fjam_next;
        rjam_reg <= rjam_next;
        lock_reg <= lock_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
    end

    // output register
    logic ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (cmd.out_load)
            ov_reg <= 1'b1;
        else if (out_ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            feeder_mode     <= mode_reg;
            position_target <= target_reg;
            speed_target    <= speed_reg;
            forward_jam     <= fjam_reg;
            reverse_jam     <= rjam_reg;
            heat_lockout    <= lock_reg;
        end
    end

    assign out_valid     = ov_reg;
    assign stat.out_busy = ov_reg && !out_ready;

endmodule

`default_nettype wire

>>> rtl/feeder_jam_and_fire_mode_controller.sv
// ----------------------------------------------------------------------------
// feeder_jam_and_fire_mode_controller
// Per-tick feeder mode machine with heat lockout, jam detection and targets.
//
// Input channel (in_valid/in_ready) carries one tick of motor and referee
// data; output channel (out_valid/out_ready) returns one result per tick.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high, write only while the block is idle.
// After an input transfer the tick is evaluated, then checked for back-off
// or, when the new mode is continuous fire, aligned to a slot, and its
// result is loaded. The slot remainder comes from a shift-subtract unit that
// resolves one bit of the 32-bit position per cycle. One item is in flight
// at a time; in_ready is high only while the sequencer waits for a tick.
// The result sits in an output register: a stalled receiver holds it and
// the next tick is accepted meanwhile, but its result waits until the
// held one is taken. Reset restores the default configuration, idle mode,
// zero targets and counters, and empties the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module feeder_jam_and_fire_mode_controller #(
    parameter int unsigned STALL_SPEED = 50
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [fjfm_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [fjfm_pkg::CfgW-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [15:0]            motor_speed,
    input  wire logic signed [31:0]            motor_position,
    input  wire logic signed [15:0]            drive_current,
    input  wire logic [15:0]                   barrel_heat,
    input  wire logic [15:0]                   barrel_heat_limit,
    input  wire logic                          stop_request,
    input  wire logic                          fire_request,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         feeder_mode,
    output logic signed [31:0]                 position_target,
    output logic signed [15:0]                 speed_target,
    output logic                               forward_jam,
    output logic                               reverse_jam,
    output logic                               heat_lockout
);
    import fjfm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    fjfm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fjfm_dp #(
        .STALL_SPEED (STALL_SPEED)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .cfg_valid         (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .motor_speed       (motor_speed),
        .motor_position    (motor_position),
        .drive_current     (drive_current),
        .barrel_heat       (barrel_heat),
        .barrel_heat_limit (barrel_heat_limit),
        .stop_request      (stop_request),
        .fire_request      (fire_request),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .feeder_mode       (feeder_mode),
        .position_target   (position_target),
        .speed_target      (speed_target),
        .forward_jam       (forward_jam),
        .reverse_jam       (reverse_jam),
        .heat_lockout      (heat_lockout)
    );

endmodule

`default_nettype wire

>>> rtl/fjfm_checker.sv
// ----------------------------------------------------------------------------
// fjfm_checker
// Port-level checks of the feeder controller, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fjfm_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [1:0]        feeder_mode,
    input wire logic signed [31:0] position_target,
    input wire logic signed [15:0] speed_target,
    input wire logic              heat_lockout
);
    import fjfm_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(feeder_mode) && $stable(position_target))
        else $error("result changed while stalled");

    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too soon after input transfer");

    a_idle_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (feeder_mode == MODE_IDLE) |-> speed_target == 16'sd0)
        else $error("idle mode with nonzero speed");

    a_lock_fire: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && heat_lockout |-> feeder_mode != MODE_FIRE)
        else $error("continuous fire under heat lockout");

endmodule

bind feeder_jam_and_fire_mode_controller fjfm_checker u_fjfm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .feeder_mode     (feeder_mode),
    .position_target (position_target),
    .speed_target    (speed_target),
    .heat_lockout    (heat_lockout)
);

`default_nettype wire

>>> bench/tb_feeder_jam_and_fire_mode_controller.sv
// ----------------------------------------------------------------------------
// tb_feeder_jam_and_fire_mode_controller
// Self-checking bench for the feeder jam and fire mode controller.
//
// A directed table covers field extremes, heat lockout, stop requests and
// slot alignment. Random ticks follow under several register settings,
// mostly stalled-motor sequences that drive the jam and back-off path.
// Every tick is run through a local predictor; each output transfer is
// compared field by field with the oldest pending table or predicted result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_feeder_jam_and_fire_mode_controller;

    import fjfm_pkg::*;

    localparam int STALL_SPEED = 50;

    typedef struct {
        logic signed [15:0] speed;
        logic signed [31:0] pos;
        logic signed [15:0] drive;
        logic [15:0]        heat;
        logic [15:0]        limit;
        logic               stop;
        logic               fire;
    } tick_in_t;

    typedef struct {
        mode_t       mode;
        logic [31:0] tgt;
        logic [15:0] spd;
        logic        fjam;
        logic        rjam;
        logic        lock;
    } tick_out_t;

    typedef struct {
        tick_in_t  t;
        bit        typed;
        tick_out_t r;
    } table_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [CfgW-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] motor_speed = '0;
    logic signed [31:0] motor_position = '0;
    logic signed [15:0] drive_current = '0;
    logic [15:0] barrel_heat = '0;
    logic [15:0] barrel_heat_limit = '0;
    logic stop_request = 1'b0;
    logic fire_request = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] feeder_mode;
    logic signed [31:0] position_target;
    logic signed [15:0] speed_target;
    logic forward_jam;
    logic reverse_jam;
    logic heat_lockout;

    feeder_jam_and_fire_mode_controller dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .motor_speed       (motor_speed),
        .motor_position    (motor_position),
        .drive_current     (drive_current),
        .barrel_heat       (barrel_heat),
        .barrel_heat_limit (barrel_heat_limit),
        .stop_request      (stop_request),
        .fire_request      (fire_request),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .feeder_mode       (feeder_mode),
        .position_target   (position_target),
        .speed_target      (speed_target),
        .forward_jam       (forward_jam),
        .reverse_jam       (reverse_jam),
        .heat_lockout      (heat_lockout)
    );

    always #1 clk = ~clk;

    // predictor copy of configuration and state
    longint c_slot, c_ftq, c_rtq, c_fticks, c_rticks, c_win, c_fire, c_heat;
    mode_t       m_mode;
    logic [31:0] m_tgt;
    logic [15:0] m_spd;
    bit          m_pend, m_fin;
    longint      m_fcnt, m_rcnt;

    tick_out_t pending_results[$];
    int fails = 0;
    int snd_pct = 0;
    int rcv_pct = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_cnt = 0;

    function automatic longint bump_count(longint c, bit up);
        if (up)
            return (c < 65535) ? c + 1 : c;
        return (c > 0) ? c - 1 : 0;
    endfunction

    function automatic tick_out_t feeder_step(tick_in_t t);
        longint pos, spd, drv, rem, stp, err;
        logic signed [31:0] ts;
        bit lk, stalled, fj, rj, fc;
        tick_out_t r;
        pos = t.pos;
        spd = t.speed;
        drv = t.drive;
        lk = (longint'(t.limit) - longint'(t.heat)) < c_heat;
        if (lk)
            m_mode = MODE_STATIC;
        stalled = ((spd < 0) ? -spd : spd) <= STALL_SPEED;
        m_fcnt = bump_count(m_fcnt, stalled && drv > c_ftq);
        m_rcnt = bump_count(m_rcnt, stalled && drv < -c_rtq);
        fj = m_fcnt > c_fticks;
        rj = m_rcnt > c_rticks;
        fc = t.fire && !lk;
        case (m_mode)
            MODE_IDLE: m_mode = t.stop ? MODE_IDLE : MODE_STATIC;
            MODE_STATIC, MODE_FIRE:
            begin
                if (t.stop)
                    m_mode = MODE_IDLE;
                else if (fj)
                begin
                    m_mode = MODE_BACK;
                    m_pend = 1'b1;
                    m_fin = 1'b0;
                end
                else
                    m_mode = fc ? MODE_FIRE : MODE_STATIC;
            end
            default:
            begin
                if (t.stop)
                    m_mode = MODE_IDLE;
                else if (!m_fin && !rj)
                    m_mode = MODE_BACK;
                else
                begin
                    m_mode = MODE_STATIC;
                    m_fin = 1'b1;
                    m_fcnt = 0;
                    m_rcnt = 0;
                end
            end
        endcase
        case (m_mode)
            MODE_IDLE:
            begin
                m_spd = '0;
                m_tgt = pos[31:0];
                m_pend = 1'b0;
                m_fin = 1'b1;
            end
            MODE_STATIC:
            begin
                m_spd = '0;
                m_fcnt = 0;
                m_rcnt = 0;
            end
            MODE_FIRE:
            begin
                rem = (c_slot > 0) ? pos % c_slot : 0;
                stp = (c_slot > 0) ? c_slot : 0;
                m_spd = c_fire[15:0];
                m_tgt = 32'(pos + stp - rem);
            end
            default:
            begin
                if (m_pend)
                begin
                    m_tgt = m_tgt - 32'(c_slot);
                    m_pend = 1'b0;
                end
                ts = m_tgt;
                err = pos - longint'(ts);
                if (err < 0)
                    err = -err;
                if (err < c_win && !m_pend)
                begin
                    m_fin = 1'b1;
                    m_fcnt = 0;
                    m_rcnt = 0;
                end
            end
        endcase
        r.mode = m_mode;
        r.tgt = m_tgt;
        r.spd = m_spd;
        r.fjam = fj;
        r.rjam = rj;
        r.lock = lk;
        return r;
    endfunction

    function automatic tick_in_t tick(longint s, longint p, longint d, longint h,
                                      longint l, bit st, bit f);
        tick_in_t t;
        t.speed = s[15:0];
        t.pos = p[31:0];
        t.drive = d[15:0];
        t.heat = h[15:0];
        t.limit = l[15:0];
        t.stop = st;
        t.fire = f;
        return t;
    endfunction

    function automatic tick_in_t random_tick();
        tick_in_t t;
        int sel;
        t.speed = 16'($urandom);
        t.pos = $urandom;
        t.drive = 16'($urandom);
        t.heat = 16'($urandom);
        t.limit = 16'($urandom);
        t.stop = 1'($urandom_range(1));
        t.fire = 1'($urandom_range(1));
        if ($urandom_range(99) < 80)
        begin
            t.speed = 16'($signed($urandom_range(120)) - 60);
            sel = $urandom_range(9);
            if (sel < 6)
                t.drive = 16'(c_ftq + 1 + $urandom_range(200));
            else if (sel < 8)
                t.drive = 16'(-c_rtq - 1 - $urandom_range(200));
            t.heat = 16'($urandom_range(200));
            t.limit = 16'($urandom_range(65535, 2000));
            if ($urandom_range(99) < 8)
                t.heat = t.limit - 16'($urandom_range(40));
            t.stop = ($urandom_range(29) == 0);
            sel = $urandom_range(2);
            if (sel == 0)
                t.pos = m_tgt + 32'($signed($urandom_range(4000)) - 2000);
            else if (sel == 1)
                t.pos = $signed($urandom_range(200000)) - 100000;
        end
        return t;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", field, got, want);
        fails++;
    endtask

    task automatic send_tick(tick_in_t t, bit typed, tick_out_t r);
        tick_out_t p;
        int gap;
        if ($urandom_range(99) < snd_pct)
        begin
            in_valid <= 1'b0;
            gap = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(3, 1);
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        motor_speed <= t.speed;
        motor_position <= t.pos;
        drive_current <= t.drive;
        barrel_heat <= t.heat;
        barrel_heat_limit <= t.limit;
        stop_request <= t.stop;
        fire_request <= t.fire;
        do @(posedge clk); while (!in_ready);
        p = feeder_step(t);
        pending_results.push_back(typed ? r : p);
    endtask

    task automatic wait_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (45) @(posedge clk);
    endtask

    // cfg_valid stays high across back-to-back writes; the caller drops it
    task automatic write_reg(cfg_idx_t idx, longint v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v[CfgW-1:0];
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_SLOT_COUNTS: c_slot = v & 20'hFFFFF;
            REG_FWD_TORQUE:  c_ftq = v & 15'h7FFF;
            REG_REV_TORQUE:  c_rtq = v & 15'h7FFF;
            REG_FWD_TICKS:   c_fticks = v & 16'hFFFF;
            REG_REV_TICKS:   c_rticks = v & 16'hFFFF;
            REG_DONE_WINDOW: c_win = v & 20'hFFFFF;
            REG_FIRE_SPEED:  c_fire = longint'($signed(v[15:0]));
            default:         c_heat = v & 10'h3FF;
        endcase
    endtask

    // receiver side: checking and backpressure
    always @(posedge clk or negedge rst_n)
    begin
        tick_out_t w;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("unexpected output transfer");
                    fails++;
                end
                else
                begin
                    w = pending_results.pop_front();
                    if (feeder_mode !== w.mode)
                        report_mismatch("feeder_mode", longint'(feeder_mode),
                                        longint'(w.mode));
                    if (position_target !== w.tgt)
                        report_mismatch("position_target", longint'(position_target),
                                        longint'($signed(w.tgt)));
                    if (speed_target !== w.spd)
                        report_mismatch("speed_target", longint'(speed_target),
                                        longint'($signed(w.spd)));
                    if (forward_jam !== w.fjam)
                        report_mismatch("forward_jam", longint'(forward_jam),
                                        longint'(w.fjam));
                    if (reverse_jam !== w.rjam)
                        report_mismatch("reverse_jam", longint'(reverse_jam),
                                        longint'(w.rjam));
                    if (heat_lockout !== w.lock)
                        report_mismatch("heat_lockout", longint'(heat_lockout),
                                        longint'(w.lock));
                end
            end
            if (hold_seen != hold_reqs)
            begin
                hold_seen = hold_reqs;
                hold_cnt = 300;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rcv_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        table_row_t rows[$];
        table_row_t row;
        tick_out_t none;
        int sent;
        none = '{MODE_IDLE, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0};
        c_slot = 36864; c_ftq = 5000; c_rtq = 5000; c_fticks = 100; c_rticks = 100;
        c_win = 1000; c_fire = 3000; c_heat = 30;
        m_mode = MODE_IDLE; m_tgt = '0; m_spd = '0; m_pend = 1'b0; m_fin = 1'b1;
        m_fcnt = 0; m_rcnt = 0;

        rows.push_back('{tick(0, 0, 0, 0, 1000, 0, 0), 1'b1,
                         '{MODE_STATIC, 32'd0, 16'd0, 1'b0, 1'b0, 1'b0}});
        rows.push_back('{tick(32767, 2147483647, 32767, 0, 65535, 0, 1), 1'b0, none});
        rows.push_back('{tick(-32768, -2147483648, -32768, 0, 65535, 0, 1), 1'b0, none});
        rows.push_back('{tick(0, -100, 0, 0, 1000, 0, 1), 1'b0, none});
        rows.push_back('{tick(10, 36864, 6000, 0, 1000, 0, 1), 1'b0, none});
        rows.push_back('{tick(0, 12345, 0, 0, 1000, 1, 0), 1'b1,
                         '{MODE_IDLE, 32'd12345, 16'd0, 1'b0, 1'b0, 1'b0}});
        rows.push_back('{tick(0, 5, 0, 65535, 0, 0, 1), 1'b1,
                         '{MODE_STATIC, 32'd12345, 16'd0, 1'b0, 1'b0, 1'b1}});
        rows.push_back('{tick(0, 7, 0, 100, 130, 0, 1), 1'b0, none});
        rows.push_back('{tick(0, 7, 0, 100, 129, 0, 1), 1'b0, none});
        rows.push_back('{tick(-50, 40000, 5001, 0, 65535, 0, 1), 1'b0, none});
        rows.push_back('{tick(51, -40000, -5001, 65535, 65535, 0, 1), 1'b0, none});
        rows.push_back('{tick(0, -2147483648, 0, 0, 1000, 1, 1), 1'b1,
                         '{MODE_IDLE, 32'h8000_0000, 16'd0, 1'b0, 1'b0, 1'b0}});
        rows.push_back('{tick(0, 73727, 0, 0, 1000, 0, 1), 1'b0, none});
        rows.push_back('{tick(0, -73727, 0, 0, 1000, 0, 1), 1'b0, none});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        snd_pct <= 18;
        rcv_pct <= 69;

        foreach (rows[i])
        begin
            row = rows[i];
            send_tick(row.t, row.typed, row.r);
        end
        sent = rows.size();

        for (int ph = 0; ph < 5; ph++)
        begin
            wait_results();
            case (ph)
                0:
                begin
                    write_reg(REG_SLOT_COUNTS, 36864);
                    write_reg(REG_FWD_TORQUE, 5000);
                    write_reg(REG_REV_TORQUE, 5000);
                    write_reg(REG_FWD_TICKS, 3);
                    write_reg(REG_REV_TICKS, 4);
                    write_reg(REG_DONE_WINDOW, 1000);
                    write_reg(REG_FIRE_SPEED, 3000);
                    write_reg(REG_HEAT_RES, 30);
                end
                1:
                begin
                    write_reg(REG_SLOT_COUNTS, 1048575);
                    write_reg(REG_FWD_TORQUE, 32767);
                    write_reg(REG_REV_TORQUE, 32767);
                    write_reg(REG_FWD_TICKS, 65535);
                    write_reg(REG_REV_TICKS, 65535);
                    write_reg(REG_DONE_WINDOW, 1048575);
                    write_reg(REG_FIRE_SPEED, 16'h8000);
                    write_reg(REG_HEAT_RES, 1023);
                end
                2:
                begin
                    write_reg(REG_SLOT_COUNTS, 0);
                    write_reg(REG_FWD_TORQUE, 0);
                    write_reg(REG_REV_TORQUE, 0);
                    write_reg(REG_FWD_TICKS, 0);
                    write_reg(REG_REV_TICKS, 0);
                    write_reg(REG_DONE_WINDOW, 0);
                    write_reg(REG_FIRE_SPEED, 32767);
                    write_reg(REG_HEAT_RES, 0);
                end
                default:
                begin
                    write_reg(REG_SLOT_COUNTS, $urandom_range(3000, 1));
                    write_reg(REG_FWD_TORQUE, $urandom_range(32767));
                    write_reg(REG_REV_TORQUE, $urandom_range(32767));
                    write_reg(REG_FWD_TICKS, $urandom_range(8));
                    write_reg(REG_REV_TICKS, $urandom_range(8));
                    write_reg(REG_DONE_WINDOW, $urandom_range(3000));
                    write_reg(REG_FIRE_SPEED, $urandom_range(65535));
                    write_reg(REG_HEAT_RES, $urandom_range(1023));
                end
            endcase
            cfg_valid <= 1'b0;
            for (int n = 0; n < 200; n++)
            begin
                if (sent == 333)
                begin
                    snd_pct <= 69;
                    rcv_pct <= 18;
                end
                else if (sent == 666)
                begin
                    snd_pct <= 0;
                    rcv_pct <= 0;
                end
                if (ph == 0 && n == 50)
                    hold_reqs <= hold_reqs + 1;
                if (ph == 3 && n == 100)
                    wait_results();
                send_tick(random_tick(), 1'b0, none);
                sent++;
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
